/* src/stack_machine_executor_top_defines.svh */
// Assertion macros for the stack machine executor.
`ifndef STACK_MACHINE_EXECUTOR_TOP_DEFINES_SVH
`define STACK_MACHINE_EXECUTOR_TOP_DEFINES_SVH

// Assert that an antecedent implies a consequent in the same cycle.
`define SME_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Assert that an antecedent implies a consequent in the next cycle.
`define SME_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* src/sme_pkg.sv */
// ----------------------------------------------------------------------------
// Stack machine executor package
// Opcodes, status codes, states and controller/datapath command types.
// ----------------------------------------------------------------------------
package sme_pkg;

    localparam logic [3:0] OP_PUSH = 4'd0;
    localparam logic [3:0] OP_POP  = 4'd1;
    localparam logic [3:0] OP_ADD  = 4'd2;
    localparam logic [3:0] OP_SUB  = 4'd3;
    localparam logic [3:0] OP_MUL  = 4'd4;
    localparam logic [3:0] OP_DIV  = 4'd5;
    localparam logic [3:0] OP_DUP  = 4'd6;
    localparam logic [3:0] OP_SWAP = 4'd7;
    localparam logic [3:0] OP_HALT = 4'd8;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_FEW     = 3'd1;
    localparam logic [2:0] ST_OVF     = 3'd2;
    localparam logic [2:0] ST_DIV0    = 3'd3;
    localparam logic [2:0] ST_INVALID = 3'd4;
    localparam logic [2:0] ST_SKIP    = 3'd5;
    localparam logic [2:0] ST_HALT    = 3'd6;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ_B,
        S_READ_A,
        S_EXEC,
        S_DIV,
        S_WRITE,
        S_WRITE2,
        S_OUT
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;   // latch the incoming request
        logic read_b;    // read the top entry
        logic read_a;    // read the entry below the top
        logic exec;      // decide and compute
        logic div_start; // start the divider
        logic div_step;  // one divider step
        logic write;     // commit stack update
        logic write2;    // second stack write of a swap
        logic finish;    // form the result
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic need_ab;   // instruction reads two operands
        logic use_div;   // instruction needs the divider
        logic div_done;  // divider in its last step
        logic need_wr2;  // instruction writes a second entry
    } stat_t;

endpackage

/* src/sme_ctrl.sv */
// ----------------------------------------------------------------------------
// Stack machine controller
// Sequences stack reads, execution, division and the result handshake.
// ----------------------------------------------------------------------------
module sme_ctrl
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    output logic          out_valid,
    input  logic          out_stall,
    input  sme_pkg::stat_t st,
    output sme_pkg::cmd_t  cmd
);

    sme_pkg::state_t state_reg, state_next;
    logic            out_valid_reg, out_valid_next;

    // State and output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sme_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            sme_pkg::S_IDLE:
                if (in_valid)
                    state_next = sme_pkg::S_READ_B;
            sme_pkg::S_READ_B:
                state_next = st.need_ab ? sme_pkg::S_READ_A : sme_pkg::S_EXEC;
            sme_pkg::S_READ_A:
                state_next = sme_pkg::S_EXEC;
            sme_pkg::S_EXEC:
                state_next = st.use_div ? sme_pkg::S_DIV : sme_pkg::S_WRITE;
            sme_pkg::S_DIV:
                if (st.div_done)
                    state_next = sme_pkg::S_WRITE;
            sme_pkg::S_WRITE:
                state_next = st.need_wr2 ? sme_pkg::S_WRITE2 : sme_pkg::S_OUT;
            sme_pkg::S_WRITE2:
                state_next = sme_pkg::S_OUT;
            sme_pkg::S_OUT:
                if (!out_valid_reg || !out_stall)
                    state_next = sme_pkg::S_IDLE;
            default:
                state_next = sme_pkg::S_IDLE;
        endcase
    end

    // Outputs.
    always_comb
    begin
        cmd            = '0;
        out_valid_next = out_valid_reg && out_stall;
        in_stall       = 1'b1;
        case (state_reg)
            sme_pkg::S_IDLE:
            begin
                in_stall    = 1'b0;
                cmd.capture = in_valid;
            end
            sme_pkg::S_READ_B: cmd.read_b = 1'b1;
            sme_pkg::S_READ_A: cmd.read_a = 1'b1;
            sme_pkg::S_EXEC:
            begin
                cmd.exec      = 1'b1;
                cmd.div_start = st.use_div;
            end
            sme_pkg::S_DIV:    cmd.div_step = 1'b1;
            sme_pkg::S_WRITE:  cmd.write = 1'b1;
            sme_pkg::S_WRITE2: cmd.write2 = 1'b1;
            sme_pkg::S_OUT:
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.finish     = 1'b1;
                    out_valid_next = 1'b1;
                end
            default: cmd = '0;
        endcase
    end

    assign out_valid = out_valid_reg;

endmodule

/* src/sme_datapath.sv */
// ----------------------------------------------------------------------------
// Stack machine datapath
// Stack memory, counters, ALU and a radix-2 signed divider.
// ----------------------------------------------------------------------------
module sme_datapath
#(
    parameter int STACK_DEPTH = 128
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  sme_pkg::cmd_t      cmd,
    output sme_pkg::stat_t     st,
    input  logic [3:0]         kind,
    input  logic signed [31:0] operand,
    output logic [2:0]         status,
    output logic signed [31:0] result_value,
    output logic               value_valid,
    output logic [7:0]         stack_depth,
    output logic               program_failed
);

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);

    logic [31:0]   mem [STACK_DEPTH];
    logic [31:0]   rd_reg;
    logic [CW-1:0] count_reg;
    logic          failed_reg;
    logic [3:0]    kind_reg;
    logic [31:0]   opnd_reg, b_reg, res_reg;
    logic [2:0]    stat_reg;
    logic [CW-1:0] cnt_new_reg;
    logic          wr_en_reg, wr2_en_reg;
    logic [AW-1:0] wr_addr_reg, wr2_addr_reg;
    logic [31:0]   wr_data_reg, wr2_data_reg;
    logic          valid_reg, fail_out_reg;
    logic [2:0]    o_status_reg;
    logic [31:0]   o_value_reg;
    logic          o_valid_reg, o_failed_reg;
    logic [7:0]    o_depth_reg;

    // Divider registers.
    logic [31:0] dq_reg, dr_reg, dd_reg;
    logic [5:0]  dcnt_reg;
    logic        dneg_q_reg;

    logic [CW-1:0] cm1, cm2;
    logic          full, active, is_binary, need_ab;
    logic [31:0]   op_a, op_b;
    assign cm1       = count_reg - CW'(1);
    assign cm2       = count_reg - CW'(2);
    assign full      = (count_reg >= CW'(STACK_DEPTH));
    assign active    = !failed_reg && kind_reg != sme_pkg::OP_HALT;
    assign is_binary = kind_reg inside {sme_pkg::OP_ADD, sme_pkg::OP_SUB, sme_pkg::OP_MUL,
                                        sme_pkg::OP_DIV, sme_pkg::OP_SWAP};
    assign need_ab   = active && count_reg >= CW'(2) && is_binary;

    // In the exec step the last read holds the lower operand when two are
    // needed, and the top entry otherwise.
    assign op_a = rd_reg;
    assign op_b = need_ab ? b_reg : rd_reg;

    // Status to the controller.
    always_comb
    begin
        st.need_ab  = need_ab;
        st.use_div  = need_ab && kind_reg == sme_pkg::OP_DIV && b_reg != '0;
        st.div_done = (dcnt_reg == 6'd1);
        st.need_wr2 = wr2_en_reg;
    end

    // Quotient with its sign restored.
    logic [31:0] div_q;
    assign div_q = dneg_q_reg ? (~dq_reg + 32'd1) : dq_reg;

    // Stack memory port: one write and one registered read per cycle.
    logic [AW-1:0] rd_addr, mem_addr;
    logic [31:0]   mem_data;
    logic          mem_we, rd_en;
    always_comb
    begin
        rd_addr  = cmd.read_a ? cm2[AW-1:0] : cm1[AW-1:0];
        rd_en    = cmd.read_b || cmd.read_a;
        mem_we   = (cmd.write && wr_en_reg) || cmd.write2;
        mem_addr = cmd.write2 ? wr2_addr_reg : wr_addr_reg;
        if (cmd.write2)
            mem_data = wr2_data_reg;
        else if (kind_reg == sme_pkg::OP_DIV)
            mem_data = div_q;
        else
            mem_data = wr_data_reg;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_addr] <= mem_data;
        if (rd_en)
            rd_reg <= mem[rd_addr];
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            failed_reg <= 1'b0;
            dcnt_reg   <= '0;
        end
        else
        begin
            if (cmd.write)
            begin
                count_reg  <= cnt_new_reg;
                failed_reg <= (kind_reg == sme_pkg::OP_HALT) ? 1'b0 :
                              (failed_reg || stat_reg == sme_pkg::ST_FEW ||
                               stat_reg == sme_pkg::ST_DIV0 ||
                               stat_reg == sme_pkg::ST_INVALID);
            end
            if (cmd.div_start)
                dcnt_reg <= 6'd32;
            else if (cmd.div_step && dcnt_reg != 6'd0)
                dcnt_reg <= dcnt_reg - 6'd1;
        end
    end

    // Absolute values for the divider.
    logic [31:0] abs_a, abs_b, dr_shift, dr_sub;
    assign abs_a    = op_a[31] ? (~op_a + 32'd1) : op_a;
    assign abs_b    = op_b[31] ? (~op_b + 32'd1) : op_b;
    assign dr_shift = {dr_reg[30:0], dq_reg[31]};
    assign dr_sub   = dr_shift - dd_reg;

    logic [31:0]   alu_r;
    logic [2:0]    ex_stat;
    logic [CW-1:0] ex_cnt;
    logic          ex_wr, ex_wr2, ex_valid;
    logic [AW-1:0] ex_addr;
    logic [31:0]   ex_data, ex_value;

    // Instruction decode and ALU. The reported value defaults to the
    // unchanged top entry.
    always_comb
    begin
        alu_r    = op_a + op_b;
        ex_stat  = sme_pkg::ST_OK;
        ex_cnt   = count_reg;
        ex_wr    = 1'b0;
        ex_wr2   = 1'b0;
        ex_addr  = count_reg[AW-1:0];
        ex_data  = opnd_reg;
        ex_value = op_b;
        ex_valid = (count_reg != '0);
        if (kind_reg == sme_pkg::OP_SUB)
            alu_r = op_a - op_b;
        else if (kind_reg == sme_pkg::OP_MUL)
            alu_r = op_a * op_b;
        if (kind_reg == sme_pkg::OP_HALT)
        begin
            ex_stat  = sme_pkg::ST_HALT;
            ex_cnt   = '0;
            ex_valid = !failed_reg && count_reg != '0;
        end
        else if (failed_reg)
            ex_stat = sme_pkg::ST_SKIP;
        else
        begin
            case (kind_reg)
                sme_pkg::OP_PUSH:
                    if (full)
                        ex_stat = sme_pkg::ST_OVF;
                    else
                    begin
                        ex_wr    = 1'b1;
                        ex_cnt   = count_reg + CW'(1);
                        ex_value = opnd_reg;
                        ex_valid = 1'b1;
                    end
                sme_pkg::OP_DUP:
                    if (count_reg == '0)
                        ex_stat = sme_pkg::ST_FEW;
                    else if (full)
                        ex_stat = sme_pkg::ST_OVF;
                    else
                    begin
                        ex_wr   = 1'b1;
                        ex_cnt  = count_reg + CW'(1);
                        ex_data = op_b;
                    end
                sme_pkg::OP_POP:
                    if (count_reg == '0)
                        ex_stat = sme_pkg::ST_FEW;
                    else
                        ex_cnt = cm1;
                sme_pkg::OP_ADD, sme_pkg::OP_SUB, sme_pkg::OP_MUL, sme_pkg::OP_DIV,
                sme_pkg::OP_SWAP:
                    if (count_reg < CW'(2))
                        ex_stat = sme_pkg::ST_FEW;
                    else if (kind_reg == sme_pkg::OP_SWAP)
                    begin
                        ex_wr    = 1'b1;
                        ex_wr2   = 1'b1;
                        ex_addr  = cm1[AW-1:0];
                        ex_data  = op_a;
                        ex_value = op_a;
                    end
                    else if (kind_reg == sme_pkg::OP_DIV && op_b == '0)
                        ex_stat = sme_pkg::ST_DIV0;
                    else
                    begin
                        ex_wr    = 1'b1;
                        ex_cnt   = cm1;
                        ex_addr  = cm2[AW-1:0];
                        ex_data  = alu_r;
                        ex_value = alu_r;
                    end
                default:
                    ex_stat = sme_pkg::ST_INVALID;
            endcase
        end
    end

    // Payload, decode and divider registers.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            kind_reg <= kind;
            opnd_reg <= operand;
        end
        if (cmd.read_a)
            b_reg <= rd_reg;
        if (cmd.exec)
        begin
            stat_reg     <= ex_stat;
            cnt_new_reg  <= ex_cnt;
            wr_en_reg    <= ex_wr;
            wr2_en_reg   <= ex_wr2;
            wr_addr_reg  <= ex_addr;
            wr_data_reg  <= ex_data;
            wr2_addr_reg <= cm2[AW-1:0];
            wr2_data_reg <= op_b;
            res_reg      <= ex_value;
            valid_reg    <= ex_valid;
            fail_out_reg <= failed_reg;
        end
        else if (cmd.write && wr_en_reg && kind_reg == sme_pkg::OP_DIV)
            res_reg <= div_q;
        if (cmd.div_start)
        begin
            dq_reg     <= abs_a;
            dd_reg     <= abs_b;
            dr_reg     <= '0;
            dneg_q_reg <= op_a[31] ^ op_b[31];
        end
        else if (cmd.div_step && dcnt_reg != 6'd0)
        begin
            if (dr_shift >= dd_reg)
            begin
                dr_reg <= dr_sub;
                dq_reg <= {dq_reg[30:0], 1'b1};
            end
            else
            begin
                dr_reg <= dr_shift;
                dq_reg <= {dq_reg[30:0], 1'b0};
            end
        end
        if (cmd.finish)
        begin
            o_status_reg <= stat_reg;
            o_failed_reg <= (kind_reg == sme_pkg::OP_HALT) ? fail_out_reg : failed_reg;
            o_depth_reg  <= 8'(count_reg);
            o_valid_reg  <= valid_reg;
            o_value_reg  <= valid_reg ? res_reg : 32'd0;
        end
    end

    assign status         = o_status_reg;
    assign result_value   = o_value_reg;
    assign value_valid    = o_valid_reg;
    assign stack_depth    = o_depth_reg;
    assign program_failed = o_failed_reg;

endmodule

/* src/stack_machine_executor_top.sv */
// ----------------------------------------------------------------------------
// Stack machine executor top level
// Runs one stack-machine instruction per request on a bounded stack.
// ----------------------------------------------------------------------------
// Channel | Handshake            | Fields
// in      | in_valid, in_stall   | kind, operand
// out     | out_valid, out_stall | status, result_value, value_valid,
//         |                      | stack_depth, program_failed
//
// One request at a time. Each request reads the top entry (and the entry below
// it with two operands), executes, writes and registers its result in the
// output step. A swap writes twice; a divide runs 32 restoring-divider steps.
// Reset clears the stack count and failure mark; stack memory is not cleared.
// A stalled result holds; the next request is then run up to the output step.
module stack_machine_executor_top
#(
    parameter int STACK_DEPTH = 128
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [3:0]         kind,
    input  logic signed [31:0] operand,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [2:0]         status,
    output logic signed [31:0] result_value,
    output logic               value_valid,
    output logic [7:0]         stack_depth,
    output logic               program_failed
);

    sme_pkg::cmd_t  cmd;
    sme_pkg::stat_t st;

    // Controller.
    sme_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .st        (st),
        .cmd       (cmd)
    );

    // Datapath.
    sme_datapath #(.STACK_DEPTH(STACK_DEPTH)) u_dp
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .st             (st),
        .kind           (kind),
        .operand        (operand),
        .status         (status),
        .result_value   (result_value),
        .value_valid    (value_valid),
        .stack_depth    (stack_depth),
        .program_failed (program_failed)
    );

endmodule

/* src/sme_checker.sv */
// ----------------------------------------------------------------------------
// Stack machine port checker
// Watches the top level's ports for result consistency.
// ----------------------------------------------------------------------------
`include "stack_machine_executor_top_defines.svh"

module sme_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [2:0]  status,
    input logic [31:0] result_value,
    input logic        value_valid,
    input logic [7:0]  stack_depth
);

    // A result with no value carries zero.
    `SME_ASSERT_SAME(a_zero_value, out_valid && !value_valid, result_value == 32'd0)
    // Halt always leaves an empty stack.
    `SME_ASSERT_SAME(a_halt_empty, out_valid && status == sme_pkg::ST_HALT,
                     stack_depth == 8'd0)
    // No new request is taken while a result is still being formed.
    `SME_ASSERT_NEXT(a_one_at_time, in_valid && !in_stall, in_stall)
    // A stalled result holds.
    `SME_ASSERT_NEXT(a_hold, out_valid && out_stall, out_valid && $stable(status))

endmodule

bind stack_machine_executor_top sme_checker u_sme_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .result_value (result_value),
    .value_valid  (value_valid),
    .stack_depth  (stack_depth)
);

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stack machine executor testbench
// Drives instruction requests through the valid/stall channel and checks
// every result request against a cycle-free model of the stack machine.
// A directed table covers the edge cases, a fill to overflow follows, then random programs.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int DEPTH = 128;

    typedef struct {
        logic [2:0]  status;
        logic [31:0] value;
        logic        vvalid;
        logic [7:0]  depth;
        logic        failed;
    } result_t;

    typedef struct {
        logic [3:0]  op;
        logic [31:0] arg;
        logic        check;
        logic [2:0]  status;
        logic [31:0] value;
    } row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [3:0] kind = 4'd0;
    logic signed [31:0] operand = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [2:0] status;
    logic signed [31:0] result_value;
    logic value_valid;
    logic [7:0] stack_depth;
    logic program_failed;

    // Model state.
    logic [31:0] stack_mem [DEPTH];
    int          stack_cnt;
    logic        fail_mark;

    result_t pending_results[$];
    int  errors = 0;
    int  results_seen = 0;
    int  halts_seen = 0;
    bit  stimulus_done = 0;
    bit  hold_receiver = 0;
    row_t directed_rows[$];

    stack_machine_executor_top #(.STACK_DEPTH(DEPTH)) dut (.*);

    always #1 clk = ~clk;

    // Signed division truncating toward zero, with the min / -1 case.
    function automatic logic [31:0] div_trunc(logic [31:0] a, logic [31:0] b);
        if (a == 32'h8000_0000 && b == 32'hFFFF_FFFF)
            return a;
        return $signed(a) / $signed(b);
    endfunction

    // Apply one instruction to the model and return its result.
    function automatic result_t execute_instr(logic [3:0] op, logic [31:0] arg);
        result_t r;
        logic [31:0] a, b;
        bit report_top;
        report_top = 1;
        r.status = sme_pkg::ST_OK;
        r.value = '0;
        r.vvalid = 0;
        if (op == sme_pkg::OP_HALT) begin
            r.status = sme_pkg::ST_HALT;
            r.failed = fail_mark;
            if (!fail_mark && stack_cnt > 0) begin
                r.value = stack_mem[stack_cnt-1];
                r.vvalid = 1;
            end
            r.depth = 0;
            stack_cnt = 0;
            fail_mark = 0;
            return r;
        end
        if (fail_mark)
            r.status = sme_pkg::ST_SKIP;
        else begin
            case (op)
                sme_pkg::OP_PUSH:
                    if (stack_cnt >= DEPTH) r.status = sme_pkg::ST_OVF;
                    else begin
                        stack_mem[stack_cnt] = arg;
                        stack_cnt++;
                    end
                sme_pkg::OP_POP:
                    if (stack_cnt == 0) r.status = sme_pkg::ST_FEW;
                    else begin
                        stack_cnt--;
                        r.value = stack_mem[stack_cnt];
                        r.vvalid = 1;
                        report_top = 0;
                    end
                sme_pkg::OP_ADD, sme_pkg::OP_SUB, sme_pkg::OP_MUL, sme_pkg::OP_DIV,
                sme_pkg::OP_SWAP:
                    if (stack_cnt < 2) r.status = sme_pkg::ST_FEW;
                    else begin
                        b = stack_mem[stack_cnt-1];
                        a = stack_mem[stack_cnt-2];
                        if (op == sme_pkg::OP_SWAP) begin
                            stack_mem[stack_cnt-1] = a;
                            stack_mem[stack_cnt-2] = b;
                        end else if (op == sme_pkg::OP_DIV && b == 0)
                            r.status = sme_pkg::ST_DIV0;
                        else begin
                            stack_cnt--;
                            case (op)
                                sme_pkg::OP_ADD: stack_mem[stack_cnt-1] = a + b;
                                sme_pkg::OP_SUB: stack_mem[stack_cnt-1] = a - b;
                                sme_pkg::OP_MUL: stack_mem[stack_cnt-1] = a * b;
                                default: stack_mem[stack_cnt-1] = div_trunc(a, b);
                            endcase
                        end
                    end
                sme_pkg::OP_DUP:
                    if (stack_cnt == 0) r.status = sme_pkg::ST_FEW;
                    else if (stack_cnt >= DEPTH) r.status = sme_pkg::ST_OVF;
                    else begin
                        stack_mem[stack_cnt] = stack_mem[stack_cnt-1];
                        stack_cnt++;
                    end
                default: r.status = sme_pkg::ST_INVALID;
            endcase
            if (r.status inside {sme_pkg::ST_FEW, sme_pkg::ST_DIV0, sme_pkg::ST_INVALID})
                fail_mark = 1;
        end
        if (report_top && stack_cnt > 0) begin
            r.value = stack_mem[stack_cnt-1];
            r.vvalid = 1;
        end
        r.depth = stack_cnt[7:0];
        r.failed = fail_mark;
        return r;
    endfunction

    function automatic int short_or_long_gap();
        int p;
        p = $urandom_range(99);
        if (p < 55) return 0;
        if (p < 93) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // Offer one request and wait until it is taken. Valid stays high when the
    // next request follows with no gap.
    task automatic send_request(logic [3:0] op, logic [31:0] arg);
        int gap;
        result_t r;
        gap = short_or_long_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        kind <= op;
        operand <= arg;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        r = execute_instr(op, arg);
        pending_results.push_back(r);
    endtask

    function automatic logic [31:0] random_value();
        case ($urandom_range(5))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'hFFFF_FFFF;
            3: return $urandom_range(0, 8);
            default: return $urandom;
        endcase
    endfunction

    // Pick the next instruction of a mostly well-formed program.
    function automatic logic [3:0] random_opcode();
        int p;
        p = $urandom_range(99);
        if (p < 1) return 4'($urandom_range(9, 15));
        if (p < 4) return sme_pkg::OP_HALT;
        if (stack_cnt < 2 && p < 60) return sme_pkg::OP_PUSH;
        if (p < 35) return sme_pkg::OP_PUSH;
        if (p < 45) return sme_pkg::OP_POP;
        if (p < 54) return sme_pkg::OP_ADD;
        if (p < 63) return sme_pkg::OP_SUB;
        if (p < 72) return sme_pkg::OP_MUL;
        if (p < 80) return sme_pkg::OP_DIV;
        if (p < 90) return sme_pkg::OP_DUP;
        return sme_pkg::OP_SWAP;
    endfunction

    function automatic row_t mk(logic [3:0] op, logic [31:0] arg, logic check = 1'b0,
                                logic [2:0] st = '0, logic [31:0] val = '0);
        row_t r;
        r.op = op; r.arg = arg; r.check = check; r.status = st; r.value = val;
        return r;
    endfunction

    // Stimulus.
    initial begin
        int n;
        logic [3:0] op;
        directed_rows = '{
            mk(sme_pkg::OP_POP, 0, 1'b1, sme_pkg::ST_FEW, 0),
            mk(sme_pkg::OP_ADD, 0, 1'b1, sme_pkg::ST_SKIP, 0),
            mk(sme_pkg::OP_HALT, 0, 1'b1, sme_pkg::ST_HALT, 0),
            mk(sme_pkg::OP_PUSH, 32'h8000_0000, 1'b1, sme_pkg::ST_OK, 32'h8000_0000),
            mk(sme_pkg::OP_PUSH, 32'hFFFF_FFFF, 1'b1, sme_pkg::ST_OK, 32'hFFFF_FFFF),
            mk(sme_pkg::OP_DIV, 0, 1'b1, sme_pkg::ST_OK, 32'h8000_0000),
            mk(sme_pkg::OP_PUSH, 32'h7FFF_FFFF),
            mk(sme_pkg::OP_ADD, 0),
            mk(sme_pkg::OP_PUSH, 32'h7FFF_FFFF),
            mk(sme_pkg::OP_MUL, 0),
            mk(sme_pkg::OP_PUSH, -7),
            mk(sme_pkg::OP_SWAP, 0),
            mk(sme_pkg::OP_SUB, 0),
            mk(sme_pkg::OP_PUSH, 2),
            mk(sme_pkg::OP_DIV, 0),
            mk(sme_pkg::OP_DUP, 0),
            mk(sme_pkg::OP_PUSH, 0),
            mk(sme_pkg::OP_DIV, 0, 1'b1, sme_pkg::ST_DIV0, 0),
            mk(sme_pkg::OP_PUSH, 5, 1'b1, sme_pkg::ST_SKIP, 0),
            mk(sme_pkg::OP_HALT, 0, 1'b1, sme_pkg::ST_HALT, 0),
            mk(sme_pkg::OP_DUP, 0, 1'b1, sme_pkg::ST_FEW, 0),
            mk(sme_pkg::OP_HALT, 0),
            mk(4'd9, 0, 1'b1, sme_pkg::ST_INVALID, 0),
            mk(4'd15, 0, 1'b1, sme_pkg::ST_SKIP, 0),
            mk(sme_pkg::OP_HALT, 0, 1'b1, sme_pkg::ST_HALT, 0)
        };
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        stack_cnt = 0;
        fail_mark = 0;
        foreach (directed_rows[i]) begin
            send_request(directed_rows[i].op, directed_rows[i].arg);
            if (directed_rows[i].check &&
                (pending_results[$].status != directed_rows[i].status ||
                 pending_results[$].value != directed_rows[i].value)) begin
                $display("%0t: table row %0d expected status %0d value %h, model %0d %h",
                         $time, i, directed_rows[i].status, directed_rows[i].value,
                         pending_results[$].status, pending_results[$].value);
                errors++;
            end
        end
        // Fill to overflow, with a long receiver hold-off while filling.
        hold_receiver = 1;
        for (int i = 0; i < DEPTH + 2; i++)
            send_request(sme_pkg::OP_PUSH, $urandom);
        send_request(sme_pkg::OP_DUP, 0);
        send_request(sme_pkg::OP_HALT, 0);
        // Random programs.
        n = 0;
        while (n < 890) begin
            op = random_opcode();
            send_request(op, random_value());
            n++;
        end
        send_request(sme_pkg::OP_HALT, 0);
        in_valid <= 1'b0;
        stimulus_done = 1;
    end

    // Receiver stall: a long hold-off once, then random gaps.
    initial begin
        int gap;
        wait (hold_receiver);
        @(posedge clk);
        out_stall <= 1'b1;
        repeat (400) @(posedge clk);
        out_stall <= 1'b0;
        forever begin
            @(posedge clk);
            if ($urandom_range(3) == 0) begin
                gap = short_or_long_gap();
                if (gap > 0) begin
                    out_stall <= 1'b1;
                    repeat (gap) @(posedge clk);
                    out_stall <= 1'b0;
                end
            end
        end
    end

    // Result checking.
    always @(posedge clk) begin
        result_t e;
        if (rst_n && out_valid && !out_stall) begin
            results_seen++;
            if (status == sme_pkg::ST_HALT) halts_seen++;
            if (pending_results.size() == 0) begin
                $display("%0t: result with none expected, status %0d", $time, status);
                errors++;
            end else begin
                e = pending_results.pop_front();
                if (status != e.status || result_value != e.value
                    || value_valid != e.vvalid || stack_depth != e.depth
                    || program_failed != e.failed) begin
                    $display("%0t: expected st=%0d val=%h vv=%0b dep=%0d pf=%0b",
                             $time, e.status, e.value, e.vvalid, e.depth, e.failed);
                    $display("%0t: actual   st=%0d val=%h vv=%0b dep=%0d pf=%0b",
                             $time, status, result_value, value_valid, stack_depth,
                             program_failed);
                    errors++;
                end
            end
        end
    end

    // End of run.
    initial begin
        wait (stimulus_done && pending_results.size() == 0);
        repeat (100) @(posedge clk);
        $display("Checked %0d results, %0d of them ending a program.",
                 results_seen, halts_seen);
        if (errors == 0 && pending_results.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // Timeout.
    initial begin
        #4000000;
        $display("simulation failed");
        $finish;
    end
endmodule
